// ===== design/fmc_pkg.sv =====
// ----------------------------------------------------------------------------
// fmc_pkg: shared types and constants for the flashlight mode controller
// Item structs, register and mode codes, timing constants and the
// saturating remote-code adjust function.
// ----------------------------------------------------------------------------
package fmc_pkg;

  // Default width of the free-running tick counter.
  localparam int TICK_BITS_DEF = 16;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Register reset values.
  localparam logic [7:0] STROBE_LEVEL_RST = 8'd200;
  localparam logic [7:0] SOS_LEVEL_RST    = 8'd250;
  localparam logic [7:0] HOLD_TICKS_RST   = 8'd125;

  // Smallest hold count that toggles the menu.
  localparam logic [7:0] HOLD_MIN = 8'd2;

  // Pattern periods and thresholds, in ticks.
  localparam logic [7:0] STROBE_PERIOD = 8'd40;
  localparam logic [7:0] STROBE_DARK   = 8'd20;
  localparam logic [7:0] SOS_PERIOD    = 8'd200;
  localparam logic [7:0] MENU_PERIOD   = 8'd100;

  // SOS sequencing: dots in the first and last groups, dashes between.
  localparam logic [4:0] SOS_FIRST_STEP = 5'd1;
  localparam logic [4:0] SOS_DOT_END    = 5'd6;
  localparam logic [4:0] SOS_DOT_BEGIN  = 5'd19;
  localparam logic [4:0] SOS_LAST_STEP  = 5'd24;

  // Remote codes and the steps they apply.
  localparam logic signed [15:0] RF_FINE   = 16'sd100;
  localparam logic signed [15:0] RF_MID    = 16'sd200;
  localparam logic signed [15:0] RF_COARSE = 16'sd300;
  localparam logic signed [9:0]  ADJ_FINE   = 10'sd1;
  localparam logic signed [9:0]  ADJ_MID    = 10'sd25;
  localparam logic signed [9:0]  ADJ_COARSE = 10'sd50;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_STROBE_LEVEL = 2'd0,
    REG_SOS_LEVEL    = 2'd1,
    REG_HOLD_TICKS   = 2'd2
  } cfg_reg_t;

  // Light modes.
  typedef enum logic [1:0] {
    MODE_STEADY  = 2'd0,
    MODE_STROBE  = 2'd1,
    MODE_VSTROBE = 2'd2,
    MODE_SOS     = 2'd3
  } mode_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN
  } state_t;

  // Input item.
  typedef struct packed {
    logic [1:0]         enc_phase;
    logic               btn_first;
    logic               btn_second;
    logic               rf_valid;
    logic signed [15:0] rf_value;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [7:0] duty;
    logic       menu_active;
    logic [1:0] light_mode;
    logic [7:0] brightness;
  } out_item_t;

  // Configuration register values.
  typedef struct packed {
    logic [7:0] strobe_level;
    logic [7:0] sos_level;
    logic [7:0] hold_ticks;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  // Apply a remote code to an 8-bit setting, saturating at 0 and 255.
  function automatic logic [7:0] adjust(input logic [7:0] v,
                                        input logic signed [15:0] code);
    logic signed [9:0] delta;
    logic signed [9:0] n;
    delta = '0;
    if (code == RF_FINE) delta = ADJ_FINE;
    else if (code == RF_MID) delta = ADJ_MID;
    else if (code == RF_COARSE) delta = ADJ_COARSE;
    else if (code == -RF_FINE) delta = -ADJ_FINE;
    else if (code == -RF_MID) delta = -ADJ_MID;
    else if (code == -RF_COARSE) delta = -ADJ_COARSE;
    n = $signed({2'b00, v}) + delta;
    if (n > 10'sd255) return 8'd255;
    else if (n < 10'sd0) return 8'd0;
    else return n[7:0];
  endfunction

endpackage

// ===== design/fmc_regs.sv =====
// ----------------------------------------------------------------------------
// fmc_regs: configuration registers
// APB-style register file holding the strobe level, SOS level and the
// button hold count; pready is tied high, so no access is stretched.
// ----------------------------------------------------------------------------
module fmc_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fmc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [fmc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [fmc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output fmc_pkg::cfg_t                   cfg
);

  logic [7:0]        strobe_level_r, strobe_level_nxt;
  logic [7:0]        sos_level_r, sos_level_nxt;
  logic [7:0]        hold_ticks_r, hold_ticks_nxt;
  logic              wr_en;
  fmc_pkg::cfg_reg_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = fmc_pkg::cfg_reg_t'(paddr[fmc_pkg::CFG_ADDR_W-1:2]);

  // Write decode.
  always_comb begin
    strobe_level_nxt = strobe_level_r;
    sos_level_nxt    = sos_level_r;
    hold_ticks_nxt   = hold_ticks_r;
    if (wr_en) begin
      unique case (reg_sel)
        fmc_pkg::REG_STROBE_LEVEL: strobe_level_nxt = pwdata[7:0];
        fmc_pkg::REG_SOS_LEVEL:    sos_level_nxt    = pwdata[7:0];
        fmc_pkg::REG_HOLD_TICKS:   hold_ticks_nxt   = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_level_r <= fmc_pkg::STROBE_LEVEL_RST;
      sos_level_r    <= fmc_pkg::SOS_LEVEL_RST;
      hold_ticks_r   <= fmc_pkg::HOLD_TICKS_RST;
    end else begin
      strobe_level_r <= strobe_level_nxt;
      sos_level_r    <= sos_level_nxt;
      hold_ticks_r   <= hold_ticks_nxt;
    end
  end

  // Read decode.
  always_comb begin
    unique case (reg_sel)
      fmc_pkg::REG_STROBE_LEVEL: prdata = {{(fmc_pkg::CFG_DATA_W-8){1'b0}}, strobe_level_r};
      fmc_pkg::REG_SOS_LEVEL:    prdata = {{(fmc_pkg::CFG_DATA_W-8){1'b0}}, sos_level_r};
      fmc_pkg::REG_HOLD_TICKS:   prdata = {{(fmc_pkg::CFG_DATA_W-8){1'b0}}, hold_ticks_r};
      default:                   prdata = '0;
    endcase
  end

  assign cfg.strobe_level = strobe_level_r;
  assign cfg.sos_level    = sos_level_r;
  assign cfg.hold_ticks   = hold_ticks_r;

endmodule

// ===== design/fmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fmc_ctrl: sequencing state machine
// Accepts an item, runs the bit-serial remainder over all TICK_BITS tick bits,
// then commits the tick into the output register.
// ----------------------------------------------------------------------------
module fmc_ctrl #(
  parameter int TICK_BITS = fmc_pkg::TICK_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output fmc_pkg::cmd_t cmd
);

  localparam int CNT_W = $clog2(TICK_BITS + 1);

  fmc_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fmc_pkg::S_IDLE;
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    bit_cnt_nxt   = bit_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      fmc_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          bit_cnt_nxt = CNT_W'(TICK_BITS);
          state_nxt   = fmc_pkg::S_DIV;
        end
      end
      fmc_pkg::S_DIV: begin
        cmd.step    = 1'b1;
        bit_cnt_nxt = bit_cnt_r - CNT_W'(1);
        if (bit_cnt_r == CNT_W'(1)) begin
          state_nxt = fmc_pkg::S_FIN;
        end
      end
      fmc_pkg::S_FIN: begin
        // Commit only when the output register is free or being emptied.
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = fmc_pkg::S_IDLE;
        end
      end
      default: state_nxt = fmc_pkg::S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != fmc_pkg::S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == fmc_pkg::S_DIV))
    else $error("accepted item did not start the remainder pass");
  a_div_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fmc_pkg::S_DIV) |-> (bit_cnt_r != '0))
    else $error("remainder pass running with an empty bit count");
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == fmc_pkg::S_FIN))
    else $error("result appeared without a finish step");
`endif

endmodule

// ===== design/fmc_dpath.sv =====
// ----------------------------------------------------------------------------
// fmc_dpath: light controller datapath
// Encoder, button and menu state, a bit-serial remainder unit for the
// pattern timing, the mode output logic and the result register.
// ----------------------------------------------------------------------------
module fmc_dpath #(
  parameter int TICK_BITS = fmc_pkg::TICK_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fmc_pkg::cmd_t      cmd,
  input  fmc_pkg::in_item_t  in_data,
  input  fmc_pkg::cfg_t      cfg,
  output fmc_pkg::out_item_t out_data
);

  // Persistent controller state.
  logic                  phase_valid_r, phase_valid_nxt;
  logic [1:0]            prev_phase_r, prev_phase_nxt;
  logic [7:0]            bright_r, bright_nxt;
  logic [7:0]            thresh_r, thresh_nxt;
  logic [1:0]            choice_r, choice_nxt;
  logic [7:0]            hold_r, hold_nxt;
  logic                  menu_r, menu_nxt;
  fmc_pkg::mode_t        mode_r, mode_nxt;
  logic [TICK_BITS-1:0]  tick_r, tick_nxt;
  logic [4:0]            sos_step_r, sos_step_nxt;
  logic                  sos_tog_r, sos_tog_nxt;
  logic [7:0]            duty_r, duty_nxt;

  // Per-item working registers.
  logic [TICK_BITS-1:0]  tsh_r, tsh_nxt;
  logic [7:0]            rem_r, rem_nxt;
  logic                  rf_valid_r, rf_valid_nxt;
  logic signed [15:0]    rf_value_r, rf_value_nxt;
  fmc_pkg::out_item_t    out_r, out_nxt;

  // Helpers.
  logic                  enc_up, enc_dn;
  logic [7:0]            hold_limit;
  logic [7:0]            div_sel;
  logic [8:0]            rem_sh;
  logic [8:0]            rem_sub;

  // Quadrature step detection against the recorded level.
  always_comb begin
    enc_up = (prev_phase_r == 2'd3 && in_data.enc_phase == 2'd1) ||
             (prev_phase_r == 2'd0 && in_data.enc_phase == 2'd2);
    enc_dn = (prev_phase_r == 2'd2 && in_data.enc_phase == 2'd0) ||
             (prev_phase_r == 2'd1 && in_data.enc_phase == 2'd3);
    hold_limit = (cfg.hold_ticks < fmc_pkg::HOLD_MIN) ? fmc_pkg::HOLD_MIN : cfg.hold_ticks;
  end

  // Divisor for this tick's pattern timing.
  always_comb begin
    if (menu_r) begin
      div_sel = fmc_pkg::MENU_PERIOD;
    end else begin
      unique case (mode_r)
        fmc_pkg::MODE_STROBE:  div_sel = fmc_pkg::STROBE_PERIOD;
        fmc_pkg::MODE_VSTROBE: div_sel = bright_r;
        fmc_pkg::MODE_SOS:     div_sel = fmc_pkg::SOS_PERIOD;
        default:               div_sel = fmc_pkg::STROBE_PERIOD;
      endcase
    end
  end

  // One restoring remainder step: bring in the next tick bit, subtract if it fits.
  always_comb begin
    rem_sh  = {rem_r, tsh_r[TICK_BITS-1]};
    rem_sub = rem_sh - {1'b0, div_sel};
  end

  // Next-state logic for load, remainder step and finish.
  always_comb begin
    phase_valid_nxt = phase_valid_r;
    prev_phase_nxt  = prev_phase_r;
    bright_nxt      = bright_r;
    thresh_nxt      = thresh_r;
    choice_nxt      = choice_r;
    hold_nxt        = hold_r;
    menu_nxt        = menu_r;
    mode_nxt        = mode_r;
    tick_nxt        = tick_r;
    sos_step_nxt    = sos_step_r;
    sos_tog_nxt     = sos_tog_r;
    duty_nxt        = duty_r;
    tsh_nxt         = tsh_r;
    rem_nxt         = rem_r;
    rf_valid_nxt    = rf_valid_r;
    rf_value_nxt    = rf_value_r;
    out_nxt         = out_r;

    if (cmd.load) begin
      // Encoder: the first sample only records the level.
      if (!phase_valid_r) begin
        phase_valid_nxt = 1'b1;
        prev_phase_nxt  = in_data.enc_phase;
      end else if (in_data.enc_phase != prev_phase_r) begin
        if (enc_up) begin
          if (!menu_r) begin
            if (bright_r != 8'd255) bright_nxt = bright_r + 8'd1;
          end else if (choice_r != 2'd3) begin
            choice_nxt = choice_r + 2'd1;
          end
        end else if (enc_dn) begin
          if (!menu_r) begin
            if (bright_r != 8'd0) bright_nxt = bright_r - 8'd1;
          end else if (choice_r != 2'd0) begin
            choice_nxt = choice_r - 2'd1;
          end
        end
        prev_phase_nxt = in_data.enc_phase;
      end

      // Button hold counter and menu toggle.
      if (in_data.btn_first) begin
        hold_nxt = in_data.btn_second ? hold_r + 8'd1 : 8'd1;
      end
      if (hold_nxt == hold_limit) begin
        menu_nxt = !menu_r;
        hold_nxt = 8'd1;
      end

      // Variable strobe never divides by zero brightness.
      if (!menu_nxt && mode_r == fmc_pkg::MODE_VSTROBE && bright_nxt == 8'd0) begin
        bright_nxt = 8'd1;
      end

      tsh_nxt      = tick_r;
      rem_nxt      = '0;
      rf_valid_nxt = in_data.rf_valid;
      rf_value_nxt = in_data.rf_value;
    end else if (cmd.step) begin
      rem_nxt = rem_sub[8] ? rem_sh[7:0] : rem_sub[7:0];
      tsh_nxt = tsh_r << 1;
    end else if (cmd.finish) begin
      // Mode output, with rem_r holding the tick modulo the chosen period.
      if (!menu_r) begin
        unique case (mode_r)
          fmc_pkg::MODE_STEADY: begin
            duty_nxt = bright_r;
          end
          fmc_pkg::MODE_STROBE: begin
            duty_nxt = (rem_r <= fmc_pkg::STROBE_DARK) ? 8'd0 : cfg.strobe_level;
          end
          fmc_pkg::MODE_VSTROBE: begin
            duty_nxt = (rem_r <= thresh_r) ? 8'd0 : cfg.strobe_level;
          end
          fmc_pkg::MODE_SOS: begin
            if (rem_r == 8'd0) begin
              duty_nxt = sos_tog_r ? 8'd0 : cfg.sos_level;
              if (sos_step_r <= fmc_pkg::SOS_DOT_END || sos_step_r >= fmc_pkg::SOS_DOT_BEGIN ||
                  !sos_step_r[0]) begin
                sos_tog_nxt = !sos_tog_r;
              end
              sos_step_nxt = (sos_step_r >= fmc_pkg::SOS_LAST_STEP) ?
                             fmc_pkg::SOS_FIRST_STEP : sos_step_r + 5'd1;
            end
          end
          default: ;
        endcase
      end else if (rem_r == 8'd0) begin
        // Menu: latch the chosen mode on the period boundary.
        mode_nxt = fmc_pkg::mode_t'(choice_r);
        duty_nxt = 8'd0;
      end

      // Remote code, acting on the mode just settled.
      if (rf_valid_r) begin
        if (mode_nxt == fmc_pkg::MODE_STEADY) begin
          bright_nxt = fmc_pkg::adjust(bright_r, rf_value_r);
        end else if (mode_nxt == fmc_pkg::MODE_VSTROBE) begin
          thresh_nxt = fmc_pkg::adjust(thresh_r, rf_value_r);
        end
      end

      tick_nxt = tick_r + TICK_BITS'(1);

      out_nxt.duty        = duty_nxt;
      out_nxt.menu_active = menu_r;
      out_nxt.light_mode  = mode_nxt;
      out_nxt.brightness  = bright_nxt;
    end
  end

  // Control state with reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_valid_r <= 1'b0;
      prev_phase_r  <= '0;
      bright_r      <= '0;
      thresh_r      <= '0;
      choice_r      <= '0;
      hold_r        <= 8'd1;
      menu_r        <= 1'b0;
      mode_r        <= fmc_pkg::MODE_STEADY;
      tick_r        <= '0;
      sos_step_r    <= fmc_pkg::SOS_FIRST_STEP;
      sos_tog_r     <= 1'b1;
      duty_r        <= '0;
    end else begin
      phase_valid_r <= phase_valid_nxt;
      prev_phase_r  <= prev_phase_nxt;
      bright_r      <= bright_nxt;
      thresh_r      <= thresh_nxt;
      choice_r      <= choice_nxt;
      hold_r        <= hold_nxt;
      menu_r        <= menu_nxt;
      mode_r        <= mode_nxt;
      tick_r        <= tick_nxt;
      sos_step_r    <= sos_step_nxt;
      sos_tog_r     <= sos_tog_nxt;
      duty_r        <= duty_nxt;
    end
  end

  // Working and result registers carry payload only.
  always_ff @(posedge clk) begin
    tsh_r      <= tsh_nxt;
    rem_r      <= rem_nxt;
    rf_valid_r <= rf_valid_nxt;
    rf_value_r <= rf_value_nxt;
    out_r      <= out_nxt;
  end

  assign out_data = out_r;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> (rem_r < div_sel))
    else $error("remainder step left a value not below the divisor");
`endif

endmodule

// ===== design/flashlight_mode_controller.sv =====
// ----------------------------------------------------------------------------
// flashlight_mode_controller: LED light mode controller, one item per tick
// Takes encoder, button and remote samples each tick and returns the PWM
// duty with the menu, mode and brightness status.
//
//   Channel | Ports                                   | Direction
//   --------+-----------------------------------------+----------
//   input   | in_valid, in_stall, in_data             | into block
//   result  | out_valid, out_stall, out_data          | out of block
//   config  | psel, penable, pwrite, paddr, pwdata,   | APB slave
//           | prdata, pready                          |
//
// Each item passes three steps: accept and update encoder and button state,
// shift the tick bits through the one-bit-per-cycle remainder unit that times
// the patterns, and commit. A new item is taken only once the last has committed.
// The next item is accepted while a result still waits in the output register.
// A stalled output holds the commit step until the register frees.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module flashlight_mode_controller #(
  parameter int TICK_BITS = fmc_pkg::TICK_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fmc_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fmc_pkg::out_item_t              out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fmc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [fmc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [fmc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  fmc_pkg::cfg_t cfg;
  fmc_pkg::cmd_t cmd;

  // Configuration registers.
  fmc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer.
  fmc_ctrl #(
    .TICK_BITS (TICK_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Datapath.
  fmc_dpath #(
    .TICK_BITS (TICK_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg      (cfg),
    .out_data (out_data)
  );

endmodule

// ===== tb/sv/tb_flashlight_mode_controller.sv =====
// ----------------------------------------------------------------------------
// tb_flashlight_mode_controller: self-checking bench for the light controller
// Drives tick items through the valid/stall input channel, predicts the duty,
// menu, mode and brightness of every tick with an internal model, and checks
// each result item against it. Register settings change between phases over
// the APB-style port; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_flashlight_mode_controller;

  // Run limits and pacing.
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 24;
  localparam int LONG_HOLD   = 400;
  localparam int HOLD_AT     = 100;

  // Remote codes that the controller acts on.
  localparam logic signed [15:0] RC_UP_FINE   = 16'sd100;
  localparam logic signed [15:0] RC_UP_MID    = 16'sd200;
  localparam logic signed [15:0] RC_UP_COARSE = 16'sd300;
  localparam logic signed [15:0] RC_DN_FINE   = -16'sd100;
  localparam logic signed [15:0] RC_DN_MID    = -16'sd200;
  localparam logic signed [15:0] RC_DN_COARSE = -16'sd300;

  // Pattern timing, in ticks.
  localparam logic [15:0] STROBE_TICKS = 16'd40;
  localparam logic [15:0] STROBE_OFF   = 16'd20;
  localparam logic [15:0] SOS_TICKS    = 16'd200;
  localparam logic [15:0] MENU_TICKS   = 16'd100;
  localparam logic [4:0]  SOS_DOTS_END = 5'd6;
  localparam logic [4:0]  SOS_DOTS_BEG = 5'd19;
  localparam logic [4:0]  SOS_STEPS    = 5'd24;

  // Block ports; the inputs that the bench drives are known from time zero.
  logic                           clk      = 1'b0;
  logic                           rst_n    = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  fmc_pkg::in_item_t              in_data  = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  fmc_pkg::out_item_t             out_data;
  logic                           psel     = 1'b0;
  logic                           penable  = 1'b0;
  logic                           pwrite   = 1'b0;
  logic [fmc_pkg::CFG_ADDR_W-1:0] paddr    = '0;
  logic [fmc_pkg::CFG_DATA_W-1:0] pwdata   = '0;
  logic [fmc_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  // Register copies seen by the light model.
  logic [7:0] cfg_strobe = 8'd200;
  logic [7:0] cfg_sos    = 8'd250;
  logic [7:0] cfg_hold   = 8'd125;

  // Light model state.
  bit             p_seen     = 1'b0;
  logic [1:0]     p_phase    = 2'd0;
  logic [7:0]     p_bright   = 8'd0;
  logic [7:0]     p_thresh   = 8'd0;
  logic [1:0]     p_choice   = 2'd0;
  logic [7:0]     p_hold     = 8'd1;
  logic           p_menu     = 1'b0;
  fmc_pkg::mode_t p_mode     = fmc_pkg::MODE_STEADY;
  logic [15:0]    p_tick     = 16'd0;
  logic [4:0]     p_sos_step = 5'd1;
  logic           p_sos_tog  = 1'b1;
  logic [7:0]     p_duty     = 8'd0;

  // Pending tick items and the status items they are due to produce.
  fmc_pkg::in_item_t  tick_queue[$];
  fmc_pkg::out_item_t due_status[$];

  // Generator bookkeeping.
  logic [1:0] g_phase = 2'd0;
  int         g_tick  = 0;

  // Pacing and scoring.
  int  fail_count  = 0;
  int  status_seen = 0;
  int  cycles      = 0;
  int  drv_left    = 0;
  bit  drv_calm    = 1'b0;
  int  drv_gap     = 0;
  int  mon_left    = 0;
  bit  mon_calm    = 1'b0;
  int  stall_left  = 0;

  flashlight_mode_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // Apply a remote code to a setting, saturating at both ends.
  function automatic logic [7:0] nudge(logic [7:0] v, logic signed [15:0] code);
    int n;
    n = v;
    case (code)
      RC_UP_FINE:   n = n + 1;
      RC_UP_MID:    n = n + 25;
      RC_UP_COARSE: n = n + 50;
      RC_DN_FINE:   n = n - 1;
      RC_DN_MID:    n = n - 25;
      RC_DN_COARSE: n = n - 50;
      default:      n = n;
    endcase
    if (n > 255) n = 255;
    if (n < 0) n = 0;
    return n[7:0];
  endfunction

  // Advance the light model by one tick and return the status it reports.
  function automatic fmc_pkg::out_item_t light_tick(fmc_pkg::in_item_t it);
    logic               up;
    logic               dn;
    logic [7:0]         thr;
    fmc_pkg::out_item_t r;
    // Encoder: the first sample only records the level.
    if (!p_seen) begin
      p_phase = it.enc_phase;
      p_seen  = 1'b1;
    end else if (it.enc_phase != p_phase) begin
      up = (p_phase == 2'd3 && it.enc_phase == 2'd1) ||
           (p_phase == 2'd0 && it.enc_phase == 2'd2);
      dn = (p_phase == 2'd2 && it.enc_phase == 2'd0) ||
           (p_phase == 2'd1 && it.enc_phase == 2'd3);
      if (up) begin
        if (!p_menu) begin
          if (p_bright != 8'd255) p_bright = p_bright + 8'd1;
        end else if (p_choice != 2'd3) begin
          p_choice = p_choice + 2'd1;
        end
      end else if (dn) begin
        if (!p_menu) begin
          if (p_bright != 8'd0) p_bright = p_bright - 8'd1;
        end else if (p_choice != 2'd0) begin
          p_choice = p_choice - 2'd1;
        end
      end
      p_phase = it.enc_phase;
    end

    // Button hold count and menu toggle.
    if (it.btn_first) p_hold = it.btn_second ? p_hold + 8'd1 : 8'd1;
    thr = (cfg_hold < 8'd2) ? 8'd2 : cfg_hold;
    if (p_hold == thr) begin
      p_menu = ~p_menu;
      p_hold = 8'd1;
    end

    // Mode output.
    if (!p_menu) begin
      case (p_mode)
        fmc_pkg::MODE_STEADY: p_duty = p_bright;
        fmc_pkg::MODE_STROBE:
          p_duty = (p_tick % STROBE_TICKS <= STROBE_OFF) ? 8'd0 : cfg_strobe;
        fmc_pkg::MODE_VSTROBE: begin
          if (p_bright == 8'd0) p_bright = 8'd1;
          p_duty = (p_tick % {8'd0, p_bright} <= {8'd0, p_thresh}) ? 8'd0 : cfg_strobe;
        end
        default: begin
          if (p_tick % SOS_TICKS == 16'd0) begin
            p_duty = p_sos_tog ? 8'd0 : cfg_sos;
            if (p_sos_step <= SOS_DOTS_END || p_sos_step >= SOS_DOTS_BEG) p_sos_tog = ~p_sos_tog;
            else if (!p_sos_step[0]) p_sos_tog = ~p_sos_tog;
            if (p_sos_step >= SOS_STEPS) p_sos_step = 5'd0;
            p_sos_step = p_sos_step + 5'd1;
          end
        end
      endcase
    end else if (p_tick % MENU_TICKS == 16'd0) begin
      p_mode = fmc_pkg::mode_t'(p_choice);
      p_duty = 8'd0;
    end

    // Remote code, acting in steady and variable strobe only.
    if (it.rf_valid) begin
      if (p_mode == fmc_pkg::MODE_STEADY) p_bright = nudge(p_bright, it.rf_value);
      else if (p_mode == fmc_pkg::MODE_VSTROBE) p_thresh = nudge(p_thresh, it.rf_value);
    end

    p_tick = p_tick + 16'd1;

    r.duty        = p_duty;
    r.menu_active = p_menu;
    r.light_mode  = p_mode;
    r.brightness  = p_bright;
    return r;
  endfunction

  // Idle cycles before the next item; stretches of zero come and go.
  function automatic int draw_wait(inout int left, inout bit calm);
    if (left == 0) begin
      left = $urandom_range(6, 40);
      calm = ($urandom_range(0, 3) == 0);
    end
    left = left - 1;
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  // Input driver: offers queued items, predicts each one as it is accepted.
  always @(posedge clk) begin
    int n;
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_gap  <= 0;
    end else if (in_valid && !in_stall) begin
      due_status.push_back(light_tick(in_data));
      n = draw_wait(drv_left, drv_calm);
      if (n == 0 && tick_queue.size() > 0) begin
        in_data <= tick_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
        drv_gap  <= n;
      end
    end else if (!in_valid) begin
      if (drv_gap > 0) begin
        drv_gap <= drv_gap - 1;
      end else if (tick_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= tick_queue.pop_front();
      end
    end
  end

  // Result monitor: checks each status item and paces the stall.
  always @(posedge clk) begin
    int                 n;
    fmc_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_status.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected status item: duty %0d menu %0d mode %0d bright %0d",
                     out_data.duty, out_data.menu_active, out_data.light_mode,
                     out_data.brightness);
        end else begin
          want = due_status.pop_front();
          if (out_data.duty !== want.duty || out_data.menu_active !== want.menu_active ||
              out_data.light_mode !== want.light_mode ||
              out_data.brightness !== want.brightness) begin
            fail_count++;
            if (fail_count <= 10)
              $display("status mismatch at item %0d: expected duty %0d menu %0d mode %0d",
                       status_seen, want.duty, want.menu_active, want.light_mode,
                       " bright %0d, got duty %0d menu %0d mode %0d bright %0d",
                       want.brightness, out_data.duty, out_data.menu_active,
                       out_data.light_mode, out_data.brightness);
          end
        end
        status_seen++;
        n = draw_wait(mon_left, mon_calm);
        // One long hold-off lets the block fill up and stall its input.
        if (status_seen == HOLD_AT) n = LONG_HOLD;
      end else begin
        n = (stall_left > 0) ? stall_left - 1 : 0;
      end
      stall_left <= n;
      out_stall  <= (n > 0);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Queue one tick item.
  task automatic push_tick(logic [1:0] ph, logic b1, logic b2, logic rv,
                           logic signed [15:0] val);
    fmc_pkg::in_item_t it;
    it.enc_phase  = ph;
    it.btn_first  = b1;
    it.btn_second = b2;
    it.rf_valid   = rv;
    it.rf_value   = val;
    tick_queue.push_back(it);
    g_phase = ph;
    g_tick++;
  endtask

  // One of the six remote codes that act.
  function automatic logic signed [15:0] random_code();
    case ($urandom_range(0, 5))
      0:       return RC_UP_FINE;
      1:       return RC_UP_MID;
      2:       return RC_UP_COARSE;
      3:       return RC_DN_FINE;
      4:       return RC_DN_MID;
      default: return RC_DN_COARSE;
    endcase
  endfunction

  // Remote traffic: mostly acting codes, sometimes any value.
  function automatic logic signed [15:0] remote_value();
    return ($urandom_range(0, 4) == 0) ? 16'($urandom) : random_code();
  endfunction

  // Ticks with the encoder still and the button up.
  task automatic quiet(int n);
    repeat (n) push_tick(g_phase, 1'b0, 1'b0, $urandom_range(0, 4) == 0, remote_value());
  endtask

  // One counted encoder step, with a lead-in level where the step needs one.
  task automatic enc_step(bit up);
    if (up) begin
      if (g_phase == 2'd1) push_tick(2'd0, 1'b0, 1'b0, 1'b0, 16'sd0);
      else if (g_phase == 2'd2) push_tick(2'd3, 1'b0, 1'b0, 1'b0, 16'sd0);
      push_tick((g_phase == 2'd3) ? 2'd1 : 2'd2, 1'b0, 1'b0, 1'b0, 16'sd0);
    end else begin
      if (g_phase == 2'd0) push_tick(2'd1, 1'b0, 1'b0, 1'b0, 16'sd0);
      else if (g_phase == 2'd3) push_tick(2'd2, 1'b0, 1'b0, 1'b0, 16'sd0);
      push_tick((g_phase == 2'd2) ? 2'd0 : 2'd3, 1'b0, 1'b0, 1'b0, 16'sd0);
    end
  endtask

  // Restart the hold count, then hold exactly long enough to toggle the menu.
  task automatic hold_toggle();
    int span;
    span = (cfg_hold < 8'd2) ? 2 : cfg_hold;
    push_tick(g_phase, 1'b1, 1'b0, 1'b0, 16'sd0);
    repeat (span - 1)
      push_tick(g_phase, 1'b1, 1'b1, $urandom_range(0, 5) == 0, remote_value());
  endtask

  // A hold that is released before it reaches the toggle count.
  task automatic broken_hold();
    int span;
    int most;
    span = (cfg_hold < 8'd2) ? 2 : cfg_hold;
    most = (span - 2 > 20) ? 20 : span - 2;
    push_tick(g_phase, 1'b1, 1'b0, 1'b0, 16'sd0);
    repeat ($urandom_range(0, most)) push_tick(g_phase, 1'b1, 1'b1, 1'b0, 16'sd0);
    if ($urandom_range(0, 1)) push_tick(g_phase, 1'b1, 1'b0, 1'b0, 16'sd0);
    else push_tick(g_phase, 1'b0, 1'($urandom_range(0, 1)), 1'b0, 16'sd0);
  endtask

  // Enter the menu, pick a mode, stay past a latch tick, and leave.
  task automatic menu_visit(int m);
    hold_toggle();
    repeat (4) enc_step(1'b0);
    repeat (m) enc_step(1'b1);
    while (g_tick % 100 != 0) quiet(1);
    quiet(1);
    hold_toggle();
  endtask

  // Random tick traffic built from well-formed gestures and some noise.
  task automatic random_phase(int target);
    int start;
    int span;
    bit dir;
    start = g_tick;
    span  = (cfg_hold < 8'd2) ? 2 : cfg_hold;
    while (g_tick - start < target) begin
      case ($urandom_range(0, 9)) inside
        [0:2]: begin
          if (span <= 12) menu_visit($urandom_range(0, 3));
          else broken_hold();
        end
        [3:4]: begin
          dir = $urandom_range(0, 1);
          repeat ($urandom_range(1, 12)) enc_step(($urandom_range(0, 6) == 0) ? !dir : dir);
        end
        [5:6]: begin
          repeat ($urandom_range(1, 5)) push_tick(g_phase, 1'b0, 1'b0, 1'b1, remote_value());
        end
        7: broken_hold();
        default: begin
          repeat ($urandom_range(1, 6))
            push_tick(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 16'($urandom));
        end
      endcase
    end
  endtask

  // Wait until every queued item has been taken and every result checked.
  task automatic wait_idle();
    while (tick_queue.size() > 0 || in_valid || due_status.size() > 0) @(posedge clk);
  endtask

  // One register write: setup cycle, access cycle, then a bus idle cycle.
  task automatic write_reg(fmc_pkg::cfg_reg_t idx, logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      fmc_pkg::REG_STROBE_LEVEL: cfg_strobe = val;
      fmc_pkg::REG_SOS_LEVEL:    cfg_sos    = val;
      default:                   cfg_hold   = val;
    endcase
  endtask

  // Change all three settings once the block has drained.
  task automatic setup(logic [7:0] s, logic [7:0] o, logic [7:0] h);
    wait_idle();
    repeat (SETTLE) @(posedge clk);
    write_reg(fmc_pkg::REG_STROBE_LEVEL, s);
    write_reg(fmc_pkg::REG_SOS_LEVEL, o);
    write_reg(fmc_pkg::REG_HOLD_TICKS, h);
  endtask

  // Stimulus sequence and final verdict.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: first sample, counted steps, jumps, saturation, codes, buttons.
    push_tick(2'd3, 1'b0, 1'b0, 1'b1, RC_UP_COARSE);
    push_tick(2'd1, 1'b0, 1'b0, 1'b0, 16'sd0);
    push_tick(2'd0, 1'b0, 1'b0, 1'b0, 16'sd0);
    push_tick(2'd2, 1'b0, 1'b0, 1'b0, 16'sd0);
    push_tick(2'd0, 1'b0, 1'b0, 1'b0, 16'sd0);
    push_tick(2'd1, 1'b0, 1'b0, 1'b1, RC_DN_COARSE);
    push_tick(2'd3, 1'b0, 1'b0, 1'b1, RC_DN_FINE);
    push_tick(2'd0, 1'b0, 1'b0, 1'b0, 16'sd0);
    push_tick(2'd3, 1'b0, 1'b0, 1'b1, RC_UP_MID);
    push_tick(2'd3, 1'b0, 1'b0, 1'b1, RC_DN_MID);
    push_tick(2'd3, 1'b0, 1'b0, 1'b1, 16'sh7FFF);
    push_tick(2'd3, 1'b0, 1'b0, 1'b1, 16'sh8000);
    push_tick(2'd3, 1'b0, 1'b0, 1'b0, RC_UP_COARSE);
    repeat (6) push_tick(2'd3, 1'b0, 1'b0, 1'b1, RC_UP_COARSE);
    push_tick(2'd1, 1'b0, 1'b0, 1'b1, RC_UP_FINE);
    push_tick(2'd1, 1'b1, 1'b1, 1'b0, 16'sd0);
    push_tick(2'd1, 1'b0, 1'b1, 1'b0, 16'sd0);
    push_tick(2'd1, 1'b1, 1'b0, 1'b0, 16'sd0);
    push_tick(2'd2, 1'b0, 1'b0, 1'b0, 16'sd0);

    // Random phases over a spread of settings, extremes included.
    setup(8'd255, 8'd0, 8'd0);
    random_phase(50);
    setup(8'd0, 8'd255, 8'd1);
    random_phase(50);
    setup(8'($urandom), 8'($urandom), 8'd255);
    random_phase(30);
    setup(8'($urandom), 8'($urandom), 8'($urandom_range(2, 6)));
    random_phase(50);
    setup(8'($urandom), 8'($urandom), 8'($urandom_range(2, 12)));
    random_phase(50);
    setup(8'($urandom), 8'($urandom), 8'd2);
    random_phase(50);

    wait_idle();
    repeat (2 * SETTLE) @(posedge clk);
    if (fail_count == 0 && due_status.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
